### src/bpa_pkg.sv
// Package with the beat types, constants and action codes of the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES_DEFAULT  = 65536;
  localparam int PAGE_SHIFT_DEFAULT = 12;
  localparam int ADDR_W = 48;
  localparam int CNT_W  = 17;
  localparam int WORD_W = 32;

  localparam logic [1:0] ACT_ALLOC     = 2'd0;
  localparam logic [1:0] ACT_FREE      = 2'd1;
  localparam logic [1:0] ACT_MARK_USED = 2'd2;
  localparam logic [1:0] ACT_MARK_FREE = 2'd3;

  localparam logic [1:0] REG_WINDOW_BASE  = 2'd0;
  localparam logic [1:0] REG_WINDOW_PAGES = 2'd1;
  localparam logic [1:0] REG_TOTAL_PAGES  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  count;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic              ok;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
  } out_beat_t;

endpackage

### src/bitmap_page_allocator_top.sv
// Top level of the bitmap first-fit page allocator: bitmap memory, word sequencer and APB registers.
//
// The allocator keeps one bit per page (1 = used) in a synchronous memory of 32-bit words and a
// free-page counter. It takes one beat at a time. A beat walks the bitmap page by page: every
// page costs one memory read, and a page whose bit changes also gets a memory write. Alloc
// scans from page 0 until it finds a run of count free pages, then goes back over the run and
// marks it used. Free and the mark actions touch count pages from their start page, clipped at
// the window end. Actions that are rejected by the range checks go straight to the result
// without touching the map. After reset a clearing pass sets every map word to all ones; no
// beat is accepted during that pass, while register writes are taken as usual. The result beat
// sits in an output register, and the next input beat is accepted only once that result has
// been taken.
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEFAULT,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpa_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output bpa_pkg::out_beat_t  out_beat,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import bpa_pkg::*;

  localparam int PIDX_W = $clog2(MAX_PAGES) + 1;  // can hold MAX_PAGES itself
  localparam int WORDS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SPAN_W = (PIDX_W > CNT_W) ? PIDX_W : CNT_W;
  localparam int FP_W   = PIDX_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Configuration registers.
  logic [ADDR_W-1:0] window_base;
  logic [CNT_W-1:0]  window_pages;
  logic [CNT_W-1:0]  total_pages;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= '0;
      window_pages <= '0;
      total_pages  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_WINDOW_BASE:  window_base  <= pwdata[ADDR_W-1:0];
        REG_WINDOW_PAGES: window_pages <= pwdata[CNT_W-1:0];
        REG_TOTAL_PAGES:  total_pages  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:3])
      REG_WINDOW_BASE:  prdata = {{(64-ADDR_W){1'b0}}, window_base};
      REG_WINDOW_PAGES: prdata = {{(64-CNT_W){1'b0}}, window_pages};
      REG_TOTAL_PAGES:  prdata = {{(64-CNT_W){1'b0}}, total_pages};
      default:          prdata = '0;
    endcase
  end

  // Window span in pages, clipped at MAX_PAGES.
  logic [SPAN_W-1:0] span;
  always_comb begin
    if ({{(SPAN_W-CNT_W){1'b0}}, window_pages} > SPAN_W'(MAX_PAGES)) span = SPAN_W'(MAX_PAGES);
    else span = {{(SPAN_W-CNT_W){1'b0}}, window_pages};
  end

  // Bitmap memory: one read port and one write port, read data registered.
  logic [WORD_W-1:0] map_mem [WORDS];
  logic [WA_W-1:0]   rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WA_W-1:0]   wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    rd_data <= map_mem[rd_addr];
  end

  // Sequencer state.
  logic [2:0]        state;
  logic [1:0]        action;
  logic [CNT_W-1:0]  count;
  logic [PIDX_W-1:0] page;      // current page
  logic [PIDX_W-1:0] stop;      // first page past the range
  logic [CNT_W-1:0]  run;       // free run length during the alloc scan
  logic              marking;   // alloc is writing its found run
  logic              set_used;
  logic              ok;
  logic [PIDX_W-1:0] start;
  logic [FP_W-1:0]   pages_free;
  logic [WA_W-1:0]   clr_addr;
  logic [WORD_W-1:0] word;      // word read for the current page
  logic              out_full;

  logic [4:0]        bit_sel;
  logic              cur_bit;

  assign bit_sel = 5'(page);
  assign cur_bit = rd_data[bit_sel];
  assign in_stall  = (state != S_IDLE) || out_full;
  assign out_valid = out_full;

  // Range checks on the incoming beat.
  logic [ADDR_W:0]   win_hi;
  logic [ADDR_W-1:0] chk_addr;
  logic              in_win;
  logic              aligned;
  logic [ADDR_W-1:0] offset;
  logic [PIDX_W-1:0] in_page;
  logic [SPAN_W:0]   range_end;

  always_comb begin
    win_hi   = {1'b0, window_base} + ((ADDR_W+1)'(span) << PAGE_SHIFT);
    aligned  = (in_beat.address[PAGE_SHIFT-1:0] == '0);
    chk_addr = (in_beat.action == ACT_FREE) ? in_beat.address
             : {in_beat.address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    in_win   = (chk_addr >= window_base) && ({1'b0, chk_addr} < win_hi);
    offset   = chk_addr - window_base;
    in_page  = PIDX_W'(offset >> PAGE_SHIFT);
    range_end = (SPAN_W+1)'(in_page) + (SPAN_W+1)'(in_beat.count);
  end

  logic in_fire;
  logic out_fire;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_full && !out_stall;

  logic [FP_W-1:0]  fp_next;
  logic [CNT_W-1:0] fc_sat;
  always_comb begin
    fc_sat = (pages_free > FP_W'(2**CNT_W - 1)) ? '1 : CNT_W'(pages_free);
  end

  always_comb begin
    rd_addr = WA_W'(page >> 5);
    wr_en   = 1'b0;
    wr_addr = WA_W'(page >> 5);
    wr_data = word;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '1;
    end else if (state == S_WRITE) begin
      wr_en = 1'b1;
      wr_data = word;
      wr_data[bit_sel] = set_used;
    end
    fp_next = set_used ? pages_free - FP_W'(1) : pages_free + FP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      pages_free <= '0;
      out_full   <= 1'b0;
      marking    <= 1'b0;
    end else begin
      if (out_fire && state != S_DONE) out_full <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WA_W'(1);
          if (clr_addr == WA_W'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            action  <= in_beat.action;
            count   <= in_beat.count;
            ok      <= 1'b0;
            marking <= 1'b0;
            run     <= '0;
            out_beat.result_address <= '0;
            state   <= S_DONE;
            if (in_beat.action == ACT_ALLOC) begin
              page <= '0;
              stop <= PIDX_W'(span);
              set_used <= 1'b1;
              if (in_beat.count != '0 && SPAN_W'(in_beat.count) <= SPAN_W'(pages_free)
                  && span != '0) state <= S_READ;
            end else begin
              page <= in_page;
              stop <= (range_end > (SPAN_W+1)'(span)) ? PIDX_W'(span)
                                                      : PIDX_W'(range_end);
              set_used <= (in_beat.action == ACT_MARK_USED);
              if (in_beat.action == ACT_FREE) begin
                if (in_beat.address != '0 && in_beat.count != '0 && aligned && in_win) begin
                  ok <= 1'b1;
                  state <= S_READ;
                end
              end else if (in_win) begin
                ok <= 1'b1;
                if (in_beat.count != '0) state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_TEST;
        end
        S_TEST: begin
          word <= rd_data;
          if (action == ACT_ALLOC && !marking) begin
            if (cur_bit) begin
              run <= '0;
              if (page + PIDX_W'(1) >= stop) state <= S_DONE;
              else begin
                page <= page + PIDX_W'(1);
                state <= S_READ;
              end
            end else if (run + CNT_W'(1) == count) begin
              start   <= page + PIDX_W'(1) - PIDX_W'(count);
              page    <= page + PIDX_W'(1) - PIDX_W'(count);
              stop    <= page + PIDX_W'(1);
              marking <= 1'b1;
              ok      <= 1'b1;
              out_beat.result_address <= window_base
                + (ADDR_W'(page + PIDX_W'(1) - PIDX_W'(count)) << PAGE_SHIFT);
              state   <= S_READ;
            end else begin
              run <= run + CNT_W'(1);
              if (page + PIDX_W'(1) >= stop) state <= S_DONE;
              else begin
                page <= page + PIDX_W'(1);
                state <= S_READ;
              end
            end
          end else if (cur_bit != set_used) begin
            state <= S_WRITE;
          end else if (page + PIDX_W'(1) >= stop) begin
            state <= S_DONE;
          end else begin
            page <= page + PIDX_W'(1);
            state <= S_READ;
          end
        end
        S_WRITE: begin
          pages_free <= fp_next;
          if (page + PIDX_W'(1) >= stop) state <= S_DONE;
          else begin
            page <= page + PIDX_W'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_full || out_fire) begin
            out_full <= 1'b1;
            out_beat.ok <= ok;
            out_beat.free_count <= fc_sat;
            out_beat.used_count <= ({1'b0, total_pages} > (CNT_W+1)'(fc_sat))
                                   ? total_pages - fc_sat : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The alloc run start must lie below the end of the run being marked.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST && marking) |-> (start < stop))
    else $error("alloc run start past its end");
  // No beat is taken while the map is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("beat accepted during clearing pass");
  // A map write from the write state only happens right after a test of the same page.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $past(state == S_TEST))
    else $error("write without preceding test");

endmodule
